>>> rtl/vfd_pkg.sv
// ----------------------------------------------------------------------------
// vfd_pkg
// Shared types, command codes and the character translation table of the
// display command interpreter.
// ----------------------------------------------------------------------------
`default_nettype none

package vfd_pkg;

   localparam int DISPLAY_CELLS_DEFAULT = 80;

   // opcode carried in the request tuser
   localparam logic OP_WORD = 1'b0;
   localparam logic OP_READ = 1'b1;

   // display word types
   localparam logic [7:0] TYPE_CHAR = 8'h03;
   localparam logic [7:0] TYPE_CMD  = 8'h02;

   // command codes
   localparam logic [7:0] CMD_CLEAR      = 8'h01;
   localparam logic [7:0] CMD_HOME       = 8'h02;
   localparam logic [7:0] CMD_HOME_ALT   = 8'h03;
   localparam logic [7:0] CMD_LEFT_LO    = 8'h10;
   localparam logic [7:0] CMD_LEFT_HI    = 8'h13;
   localparam logic [7:0] CMD_RIGHT      = 8'h0e;
   localparam logic [7:0] CMD_RIGHT_LO   = 8'h14;
   localparam logic [7:0] CMD_RIGHT_HI   = 8'h17;
   localparam logic [7:0] CMD_LOAD_FLAG  = 8'h80;
   localparam logic [7:0] CMD_LOAD_MASK  = 8'h7f;

   // character filter
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_PRINT_HI  = 8'h7e;
   localparam logic [7:0] CHAR_KEEP_A    = 8'haf;
   localparam logic [7:0] CHAR_KEEP_B    = 8'hbb;

   // one store operation, issued by the cursor unit to the cell store
   typedef struct packed {
      logic       write;
      logic [6:0] addr;
      logic [7:0] data;
      logic       clear;
   } vfd_store_op_type;

   localparam logic [7:0] CHARSET_MAP [256] = '{
      8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
      8'h08, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f,
      8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17,
      8'h18, 8'h19, 8'h1a, 8'h1b, 8'h1c, 8'h1d, 8'h1e, 8'h1f,
      8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
      8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h2d, 8'h2e, 8'h2f,
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e, 8'h3f,
      8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47,
      8'h48, 8'h49, 8'h4a, 8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h4f,
      8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57,
      8'h58, 8'h59, 8'h5a, 8'h5b, 8'ha5, 8'h5d, 8'h5e, 8'h5f,
      8'h60, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67,
      8'h68, 8'h69, 8'h6a, 8'h6b, 8'h6c, 8'h6d, 8'h6e, 8'h6f,
      8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77,
      8'h78, 8'h79, 8'h7a, 8'h7b, 8'h7c, 8'h7d, 8'hbb, 8'hab,
      8'hc4, 8'hc3, 8'hc5, 8'he1, 8'he5, 8'h85, 8'hd6, 8'hf6,
      8'hd8, 8'hf8, 8'hdc, 8'h8b, 8'h5c, 8'h8d, 8'h7e, 8'ha7,
      8'hc6, 8'he6, 8'ha3, 8'h93, 8'hb7, 8'h6f, 8'h96, 8'h97,
      8'ha6, 8'hc7, 8'h9a, 8'h9b, 8'h9c, 8'h9d, 8'h9e, 8'h9f,
      8'ha0, 8'ha1, 8'ha2, 8'hac, 8'ha4, 8'hb7, 8'ha6, 8'ha7,
      8'ha8, 8'ha9, 8'haa, 8'hab, 8'hac, 8'had, 8'hae, 8'haf,
      8'h2d, 8'hb1, 8'hb2, 8'hb3, 8'hb4, 8'hb5, 8'hb6, 8'hb1,
      8'hb8, 8'hb9, 8'hba, 8'hbb, 8'hbc, 8'hbd, 8'hbe, 8'hbf,
      8'hc0, 8'hc1, 8'hc2, 8'hc3, 8'hc4, 8'hc5, 8'hc6, 8'hc7,
      8'hc8, 8'hc9, 8'hca, 8'hcb, 8'hcc, 8'hcd, 8'hce, 8'hcf,
      8'hd0, 8'hd1, 8'hd2, 8'hd3, 8'hd4, 8'hd5, 8'hd6, 8'hd7,
      8'hd8, 8'hd9, 8'hda, 8'hdb, 8'hdc, 8'hdd, 8'ha8, 8'hb0,
      8'he0, 8'he4, 8'hdf, 8'he3, 8'hb5, 8'he5, 8'h70, 8'h67,
      8'he8, 8'he9, 8'h6a, 8'ha4, 8'ha2, 8'hed, 8'hf1, 8'hf6,
      8'h70, 8'h71, 8'hf2, 8'hf3, 8'hf4, 8'hfc, 8'hf6, 8'hf7,
      8'hf8, 8'h79, 8'hfa, 8'hfb, 8'hfc, 8'hf7, 8'hfe, 8'hff
   };

   // translate a code and replace anything not displayable by a space
   function automatic logic [7:0] vfd_translate(input logic [7:0] code);
      logic [7:0] v;
      v = CHARSET_MAP[code];
      if (v == CHAR_KEEP_A || v == CHAR_KEEP_B) begin
         return v;
      end else if (v >= CHAR_SPACE && v <= CHAR_PRINT_HI) begin
         return v;
      end else begin
         return CHAR_SPACE;
      end
   endfunction

endpackage

`default_nettype wire

>>> rtl/vfd_cursor.sv
// ----------------------------------------------------------------------------
// vfd_cursor
// Cursor register and display word decode; issues character writes and
// clears to the cell store.
// ----------------------------------------------------------------------------
`default_nettype none

module vfd_cursor #(
   parameter int DISPLAY_CELLS = vfd_pkg::DISPLAY_CELLS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      step,
   input  wire logic                      opcode,
   input  wire logic [7:0]                word_type,
   input  wire logic [7:0]                word_code,
   output      logic [6:0]                cursor_next,
   output      vfd_pkg::vfd_store_op_type store_op
);
   import vfd_pkg::*;

   localparam logic [7:0] SIZE8 = 8'(DISPLAY_CELLS);
   localparam logic [7:0] LAST8 = 8'(DISPLAY_CELLS - 1);

   logic [6:0] cursor_ff;
   logic [6:0] cursor_in;
   logic [7:0] cursor_plus;

   assign cursor_plus = {1'b0, cursor_ff} + 8'd1;

   always_comb begin
      cursor_in = cursor_ff;
      store_op  = '0;
      if (step && opcode == OP_WORD) begin
         if (word_type == TYPE_CHAR) begin
            // characters past the store are dropped and the cursor holds
            if ({1'b0, cursor_ff} < SIZE8) begin
               store_op.write = 1'b1;
               store_op.addr  = cursor_ff;
               store_op.data  = vfd_translate(word_code);
               cursor_in      = cursor_plus[6:0];
            end
         end else if (word_type == TYPE_CMD) begin
            if (word_code == CMD_CLEAR) begin
               store_op.clear = 1'b1;
               cursor_in      = '0;
            end else if (word_code == CMD_HOME || word_code == CMD_HOME_ALT) begin
               cursor_in = '0;
            end else if (word_code >= CMD_LEFT_LO && word_code <= CMD_LEFT_HI) begin
               if (cursor_ff != '0) begin
                  cursor_in = cursor_ff - 7'd1;
               end
            end else if (word_code == CMD_RIGHT ||
                         (word_code >= CMD_RIGHT_LO && word_code <= CMD_RIGHT_HI)) begin
               cursor_in = (cursor_plus >= SIZE8) ? LAST8[6:0] : cursor_plus[6:0];
            end else if ((word_code & CMD_LOAD_FLAG) != '0) begin
               cursor_in = 7'(word_code & CMD_LOAD_MASK);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
      end else begin
         cursor_ff <= cursor_in;
      end
   end

   assign cursor_next = cursor_in;

endmodule

`default_nettype wire

>>> rtl/vfd_cell_store.sv
// ----------------------------------------------------------------------------
// vfd_cell_store
// Display cell memory with per-cell valid bits; an invalid cell reads as the
// fill value (zero after reset, space after a clear). Registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module vfd_cell_store #(
   parameter int DISPLAY_CELLS = vfd_pkg::DISPLAY_CELLS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire vfd_pkg::vfd_store_op_type store_op,
   input  wire logic                      rd_load,
   input  wire logic                      rd_req,
   input  wire logic [6:0]                rd_addr,
   output      logic [7:0]                cell_char
);
   import vfd_pkg::*;

   localparam int   ADDR_W = (DISPLAY_CELLS > 1) ? $clog2(DISPLAY_CELLS) : 1;
   localparam logic [7:0] SIZE8 = 8'(DISPLAY_CELLS);

   logic [7:0]               mem [DISPLAY_CELLS];
   logic [DISPLAY_CELLS-1:0] valid_ff;
   logic [7:0]               fill_ff;
   logic [7:0]               mem_rd_ff;
   logic                     rd_sel_ff;
   logic [7:0]               rd_base_ff;

   logic [ADDR_W-1:0] wr_idx;
   logic [ADDR_W-1:0] rd_idx;
   logic              rd_in_range;
   logic              rd_sel_in;
   logic [7:0]        rd_base_in;

   assign wr_idx      = store_op.addr[ADDR_W-1:0];
   assign rd_in_range = {1'b0, rd_addr} < SIZE8;
   assign rd_idx      = rd_in_range ? rd_addr[ADDR_W-1:0] : '0;

   always_comb begin
      rd_sel_in  = 1'b0;
      rd_base_in = '0;
      if (rd_req && rd_in_range) begin
         if (valid_ff[rd_idx]) begin
            rd_sel_in = 1'b1;
         end else begin
            rd_base_in = fill_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_op.write) begin
         mem[wr_idx] <= store_op.data;
      end
      if (rd_load) begin
         mem_rd_ff <= mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         fill_ff  <= '0;
      end else if (store_op.clear) begin
         valid_ff <= '0;
         fill_ff  <= CHAR_SPACE;
      end else if (store_op.write) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_load) begin
         rd_sel_ff  <= rd_sel_in;
         rd_base_ff <= rd_base_in;
      end
   end

   assign cell_char = rd_sel_ff ? mem_rd_ff : rd_base_ff;

endmodule

`default_nettype wire

>>> rtl/vfd_display_command_interpreter.sv
// ----------------------------------------------------------------------------
// vfd_display_command_interpreter
// A request beat is captured in the staging register and moves on to
// the result register once that is empty or its beat is taken. Throughput:
// one beat per cycle while the receiver takes every result, set by the single
// cursor register update and the one-write, one-read cell memory port pair.
// Reset clears the cursor, the cell valid bits and both beat registers at
// once; the store then reads as zero until written or cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module vfd_display_command_interpreter #(
   parameter int DISPLAY_CELLS = vfd_pkg::DISPLAY_CELLS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request beat
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [23:0] req_tdata,   // word_type, word_code, read_addr, zero pad
   input  wire logic        req_tuser,   // opcode
   input  wire logic        req_tlast,   // end_of_packet
   // result beat
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata    // cell_char, cursor_pos, char_written,
                                         // written_addr, written_char, store_cleared
);
   import vfd_pkg::*;

   logic       s1_valid_ff, s1_valid_in;
   logic       s1_opcode_ff;
   logic [7:0] s1_type_ff;
   logic [7:0] s1_code_ff;
   logic [6:0] s1_raddr_ff;
   logic       s1_last_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [6:0] rsp_cursor_ff;
   logic       rsp_written_ff;
   logic [6:0] rsp_waddr_ff;
   logic [7:0] rsp_wchar_ff;
   logic       rsp_cleared_ff;

   logic             req_fire;
   logic             advance;
   logic             step;
   logic [6:0]       cursor_next;
   logic [7:0]       cell_char;
   vfd_store_op_type store_op;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = s1_valid_ff && advance;
   assign req_tready = !s1_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign s1_valid_in  = req_fire ? 1'b1 : (step ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = step ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_opcode_ff <= req_tuser;
         s1_type_ff   <= req_tdata[7:0];
         s1_code_ff   <= req_tdata[15:8];
         s1_raddr_ff  <= req_tdata[22:16];
         s1_last_ff   <= req_tlast;
      end
   end

   vfd_cursor #(
      .DISPLAY_CELLS(DISPLAY_CELLS)
   ) u_cursor (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .opcode     (s1_opcode_ff),
      .word_type  (s1_type_ff),
      .word_code  (s1_code_ff),
      .cursor_next(cursor_next),
      .store_op   (store_op)
   );

   vfd_cell_store #(
      .DISPLAY_CELLS(DISPLAY_CELLS)
   ) u_cell_store (
      .clock    (clock),
      .reset    (reset),
      .store_op (store_op),
      .rd_load  (step),
      .rd_req   (s1_opcode_ff == OP_READ),
      .rd_addr  (s1_raddr_ff),
      .cell_char(cell_char)
   );

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_cursor_ff  <= cursor_next;
         rsp_written_ff <= store_op.write;
         rsp_waddr_ff   <= store_op.addr;
         rsp_wchar_ff   <= store_op.data;
         rsp_cleared_ff <= store_op.clear;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_cleared_ff, rsp_wchar_ff, rsp_waddr_ff, rsp_written_ff,
                        rsp_cursor_ff, cell_char};

   // packet marker has no effect on state; a held stage keeps its captured marker
   a_last_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !step) |=> $stable(s1_last_ff))
      else $error("staged end-of-packet marker changed while held");

   a_step_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("staged beat did not reach the result register");

   a_write_advance: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_written_ff) |-> (rsp_cursor_ff == 7'(rsp_waddr_ff + 7'd1)))
      else $error("cursor did not advance past the written cell");

   a_clear_home: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_cleared_ff) |->
         (rsp_cursor_ff == '0 && !rsp_written_ff && cell_char == '0))
      else $error("clear beat carries a cursor, write or cell value");

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the display command interpreter. A short table of
// display words and reads runs first, then about 1450 random beats with a
// mix of characters, cursor commands, clears, reads and ignored word types.
// Every result beat is compared field by field with a directed literal or
// with an in-bench model of the cell store and cursor.
// ----------------------------------------------------------------------------

module tb_top;

   import vfd_pkg::*;

   localparam int CELLS         = DISPLAY_CELLS_DEFAULT;
   localparam int RANDOM_BEATS  = 1450;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int REPORT_LIMIT  = 10;
   localparam int DIRECTED_ROWS = 25;

   // result beat, cell_char in the lowest bits
   typedef struct packed {
      logic       store_cleared;
      logic [7:0] written_char;
      logic [6:0] written_addr;
      logic       char_written;
      logic [6:0] cursor_pos;
      logic [7:0] cell_char;
   } display_result_t;

   // request tdata, word_type in the lowest bits
   typedef struct packed {
      logic       pad;
      logic [6:0] read_addr;
      logic [7:0] word_code;
      logic [7:0] word_type;
   } display_word_t;

   typedef struct packed {
      logic            opcode;
      logic [7:0]      word_type;
      logic [7:0]      word_code;
      logic [6:0]      read_addr;
      logic            end_of_packet;
      logic            known;
      display_result_t result;
   } directed_row_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // word_type, word_code, read_addr, zero pad
   logic        req_tuser;   // opcode
   logic        req_tlast;   // end_of_packet
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // cell_char, cursor_pos, char_written,
                             // written_addr, written_char, store_cleared

   logic [7:0]      cell_store [CELLS];
   logic [6:0]      cursor_now;
   display_result_t expected_results [$];
   int              mismatch_count;
   int              cycle_count;
   bit              calm;

   // cursor-load codes carry the target address in the low seven bits
   directed_row_t directed_rows [DIRECTED_ROWS] = '{
      '{OP_READ, 8'h00,    8'h00, 7'd0,   1'b0, 1'b1, '{1'b0, 8'h00, 7'd0, 1'b0, 7'd0, 8'h00}},
      '{OP_READ, TYPE_CHAR, 8'hff, 7'd127, 1'b0, 1'b1, '{1'b0, 8'h00, 7'd0, 1'b0, 7'd0, 8'h00}},
      '{OP_WORD, TYPE_CHAR, 8'h41, 7'd0,   1'b0, 1'b1, '{1'b0, 8'h41, 7'd0, 1'b1, 7'd1, 8'h00}},
      '{OP_WORD, TYPE_CHAR, 8'h00, 7'd127, 1'b0, 1'b1, '{1'b0, 8'h20, 7'd1, 1'b1, 7'd2, 8'h00}},
      '{OP_WORD, TYPE_CHAR, 8'h7e, 7'd0,   1'b0, 1'b1, '{1'b0, 8'hbb, 7'd2, 1'b1, 7'd3, 8'h00}},
      '{OP_WORD, TYPE_CHAR, 8'hff, 7'd0,   1'b0, 1'b0, '0},
      '{OP_WORD, TYPE_CHAR, 8'haf, 7'd0,   1'b1, 1'b0, '0},
      '{OP_WORD, TYPE_CMD, CMD_LEFT_LO,  7'd0, 1'b0, 1'b0, '0},
      '{OP_WORD, TYPE_CMD, CMD_RIGHT,    7'd0, 1'b0, 1'b0, '0},
      '{OP_WORD, TYPE_CMD, CMD_RIGHT_HI, 7'd0, 1'b0, 1'b0, '0},
      '{OP_WORD, TYPE_CMD, CMD_HOME,     7'd0, 1'b0, 1'b1, '{1'b0, 8'h00, 7'd0, 1'b0, 7'd0, 8'h00}},
      '{OP_WORD, TYPE_CMD, CMD_LEFT_HI,  7'd0, 1'b0, 1'b1, '{1'b0, 8'h00, 7'd0, 1'b0, 7'd0, 8'h00}},
      '{OP_WORD, TYPE_CMD, CMD_LOAD_FLAG | 8'd79, 7'd0, 1'b0, 1'b1,
        '{1'b0, 8'h00, 7'd0, 1'b0, 7'd79, 8'h00}},
      '{OP_WORD, TYPE_CMD, CMD_RIGHT_LO + 8'd1, 7'd0, 1'b0, 1'b1,
        '{1'b0, 8'h00, 7'd0, 1'b0, 7'd79, 8'h00}},
      '{OP_WORD, TYPE_CHAR, 8'h5a, 7'd0, 1'b0, 1'b0, '0},
      '{OP_WORD, TYPE_CHAR, 8'h30, 7'd0, 1'b0, 1'b1, '{1'b0, 8'h00, 7'd0, 1'b0, 7'd80, 8'h00}},
      '{OP_WORD, TYPE_CMD, CMD_LOAD_FLAG | CMD_LOAD_MASK, 7'd0, 1'b0, 1'b1,
        '{1'b0, 8'h00, 7'd0, 1'b0, 7'd127, 8'h00}},
      '{OP_WORD, TYPE_CMD, CMD_RIGHT_LO + 8'd2, 7'd0, 1'b0, 1'b1,
        '{1'b0, 8'h00, 7'd0, 1'b0, 7'd79, 8'h00}},
      '{OP_WORD, TYPE_CMD, CMD_LOAD_FLAG | 8'd126, 7'd0, 1'b0, 1'b0, '0},
      '{OP_WORD, TYPE_CMD, CMD_LEFT_LO + 8'd2, 7'd0, 1'b0, 1'b0, '0},
      '{OP_WORD, 8'hff, CMD_CLEAR, 7'd0, 1'b1, 1'b0, '0},
      '{OP_READ, 8'h00, 8'h00, 7'd79, 1'b0, 1'b0, '0},
      '{OP_WORD, TYPE_CMD, CMD_CLEAR, 7'd0, 1'b0, 1'b1, '{1'b1, 8'h00, 7'd0, 1'b0, 7'd0, 8'h00}},
      '{OP_READ, 8'h00, 8'h00, 7'd5, 1'b0, 1'b1, '{1'b0, 8'h00, 7'd0, 1'b0, 7'd0, 8'h20}},
      '{OP_WORD, TYPE_CMD, CMD_HOME_ALT, 7'd0, 1'b0, 1'b0, '0}
   };

   vfd_display_command_interpreter #(
      .DISPLAY_CELLS(CELLS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] printable_or_space(input logic [7:0] v);
      if (v == CHAR_KEEP_A || v == CHAR_KEEP_B) begin
         return v;
      end else if (v >= CHAR_SPACE && v <= CHAR_PRINT_HI) begin
         return v;
      end
      return CHAR_SPACE;
   endfunction

   // applies one beat to the cell store and cursor, returns the result beat
   function automatic display_result_t apply_display_beat(input logic opcode,
                                                           input display_word_t w);
      display_result_t r;
      logic [7:0]      ch;
      int              next;
      r = '0;
      if (opcode == OP_READ) begin
         if (w.read_addr < CELLS) r.cell_char = cell_store[w.read_addr];
      end else if (w.word_type == TYPE_CHAR) begin
         ch = printable_or_space(CHARSET_MAP[w.word_code]);
         // a cursor parked past the store drops the character
         if (cursor_now < CELLS) begin
            cell_store[cursor_now] = ch;
            r.char_written = 1'b1;
            r.written_addr = cursor_now;
            r.written_char = ch;
            cursor_now     = cursor_now + 7'd1;
         end
      end else if (w.word_type == TYPE_CMD) begin
         if (w.word_code == CMD_CLEAR) begin
            for (int i = 0; i < CELLS; i++) cell_store[i] = CHAR_SPACE;
            cursor_now      = '0;
            r.store_cleared = 1'b1;
         end else if (w.word_code == CMD_HOME || w.word_code == CMD_HOME_ALT) begin
            cursor_now = '0;
         end else if (w.word_code >= CMD_LEFT_LO && w.word_code <= CMD_LEFT_HI) begin
            if (cursor_now != 0) cursor_now = cursor_now - 7'd1;
         end else if (w.word_code == CMD_RIGHT ||
                      (w.word_code >= CMD_RIGHT_LO && w.word_code <= CMD_RIGHT_HI)) begin
            next = int'(cursor_now) + 1;
            if (next >= CELLS) next = CELLS - 1;
            cursor_now = 7'(next);
         end else if ((w.word_code & CMD_LOAD_FLAG) != 0) begin
            cursor_now = w.word_code[6:0];
         end
      end
      r.cursor_pos = cursor_now;
      return r;
   endfunction

   task automatic send_beat(input logic opcode, input display_word_t w, input logic last,
                            input logic known, input display_result_t literal);
      display_result_t predicted;
      while (!calm && $urandom_range(99) < 17) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      req_tuser  <= opcode;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = apply_display_beat(opcode, w);
      expected_results.push_back(known ? literal : predicted);
      @(negedge clock);
   endtask

   task automatic random_beat(output logic opcode, output display_word_t w,
                              output logic last);
      int kind;
      int sub;
      w.pad       = 1'b0;
      w.read_addr = 7'($urandom_range(127));
      w.word_code = 8'($urandom_range(255));
      w.word_type = TYPE_CHAR;
      last        = 1'($urandom_range(1));
      opcode      = OP_WORD;
      kind        = $urandom_range(99);
      if (kind < 15) begin
         opcode = OP_READ;
         w.word_type = 8'($urandom_range(255));
         if ($urandom_range(4) != 0) w.read_addr = 7'($urandom_range(CELLS - 1));
      end else if (kind < 60) begin
         w.word_type = TYPE_CHAR;
      end else if (kind < 90) begin
         w.word_type = TYPE_CMD;
         sub = $urandom_range(99);
         if (sub < 3) begin
            w.word_code = CMD_CLEAR;
         end else if (sub < 10) begin
            w.word_code = $urandom_range(1) ? CMD_HOME : CMD_HOME_ALT;
         end else if (sub < 35) begin
            w.word_code = 8'($urandom_range(CMD_LEFT_HI, CMD_LEFT_LO));
         end else if (sub < 60) begin
            w.word_code = ($urandom_range(4) == 0) ? CMD_RIGHT
                          : 8'($urandom_range(CMD_RIGHT_HI, CMD_RIGHT_LO));
         end else if (sub < 85) begin
            // mostly inside the store, now and then past its end
            w.word_code = CMD_LOAD_FLAG | 8'(($urandom_range(4) == 0)
                          ? $urandom_range(127, CELLS) : $urandom_range(CELLS - 1));
         end
      end else begin
         w.word_type = 8'($urandom_range(255));
      end
   endtask

   task automatic note_mismatch(input string field, input int exp_val, input int act_val);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("mismatch on %s: expected 0x%0h, got 0x%0h", field, exp_val, act_val);
      end
   endtask

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 17);
   end

   always @(posedge clock) begin
      display_result_t got;
      display_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("unexpected result beat 0x%08h", rsp_tdata);
            end
         end else begin
            want = expected_results.pop_front();
            if (got.cell_char != want.cell_char)
               note_mismatch("cell_char", want.cell_char, got.cell_char);
            if (got.cursor_pos != want.cursor_pos)
               note_mismatch("cursor_pos", want.cursor_pos, got.cursor_pos);
            if (got.char_written != want.char_written)
               note_mismatch("char_written", want.char_written, got.char_written);
            if (got.written_addr != want.written_addr)
               note_mismatch("written_addr", want.written_addr, got.written_addr);
            if (got.written_char != want.written_char)
               note_mismatch("written_char", want.written_char, got.written_char);
            if (got.store_cleared != want.store_cleared)
               note_mismatch("store_cleared", want.store_cleared, got.store_cleared);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      logic          opcode;
      logic          last;
      display_word_t w;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = OP_WORD;
      req_tlast      = 1'b0;
      rsp_tready     = 1'b0;
      calm           = 1'b0;
      mismatch_count = 0;
      cycle_count    = 0;
      cursor_now     = '0;
      for (int i = 0; i < CELLS; i++) cell_store[i] = 8'h00;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         w = '{1'b0, directed_rows[i].read_addr, directed_rows[i].word_code,
               directed_rows[i].word_type};
         send_beat(directed_rows[i].opcode, w, directed_rows[i].end_of_packet,
                   directed_rows[i].known, directed_rows[i].result);
      end

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         calm = (n >= 400 && n < 650);
         if (n == 900) begin
            // hold off until the result stream has drained
            req_tvalid <= 1'b0;
            @(negedge clock);
            while (expected_results.size() != 0) @(negedge clock);
         end
         random_beat(opcode, w, last);
         send_beat(opcode, w, last, 1'b0, '0);
      end

      req_tvalid <= 1'b0;
      @(negedge clock);
      while (expected_results.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/vfd_pkg.sv
rtl/vfd_cursor.sv
rtl/vfd_cell_store.sv
rtl/vfd_display_command_interpreter.sv
verif/tb_top.sv
